// ===== sv/euler_xyz_vertex_rotation_defines.svh =====
// Assertion macros for the Euler X-Y-Z vertex rotation block.
// No dependencies; included by the top level only.
`ifndef EULER_XYZ_VERTEX_ROTATION_DEFINES_SVH
`define EULER_XYZ_VERTEX_ROTATION_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define EXR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-qualified.
`define EXR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/exr_pkg.sv =====
// Shared types, widths and rounding helpers for the Euler X-Y-Z rotation block.
// No dependencies; used by exr_axis_stage and euler_xyz_vertex_rotation.
package exr_pkg;

  localparam int POS_W       = 32;
  localparam int NORM_W      = 16;
  localparam int COEF_W      = 16;
  localparam int FRAC_SHIFT  = 14;
  localparam int HALF        = 1 << (FRAC_SHIFT - 1);
  localparam int POS_PROD_W  = POS_W + COEF_W;
  localparam int POS_SUM_W   = POS_PROD_W + 2;
  localparam int NORM_PROD_W = NORM_W + COEF_W;
  localparam int NORM_SUM_W  = NORM_PROD_W + 2;
  localparam int VERT_W      = 3 * POS_W + 3 * NORM_W;
  localparam int TDATA_W     = ((VERT_W + 7) / 8) * 8;
  localparam int AXIS_EN_W   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = COEF_W;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Z   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_EN = 3'd6;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_SHIFT);

  // One vertex; pos_x sits in the lowest bits.
  typedef struct packed {
    logic signed [NORM_W-1:0] norm_z;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_x;
  } vert_t;

  // Vertex seen by one axis: a and b rotate, o passes.
  typedef struct packed {
    logic signed [POS_W-1:0]  pos_a;
    logic signed [POS_W-1:0]  pos_b;
    logic signed [POS_W-1:0]  pos_o;
    logic signed [NORM_W-1:0] norm_a;
    logic signed [NORM_W-1:0] norm_b;
    logic signed [NORM_W-1:0] norm_o;
  } pair_t;

  typedef struct packed {
    logic                     en;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] s;
  } axis_cfg_t;

  typedef struct packed {
    logic signed [POS_PROD_W-1:0]  pos_ac;
    logic signed [POS_PROD_W-1:0]  pos_bs;
    logic signed [POS_PROD_W-1:0]  pos_as;
    logic signed [POS_PROD_W-1:0]  pos_bc;
    logic signed [NORM_PROD_W-1:0] norm_ac;
    logic signed [NORM_PROD_W-1:0] norm_bs;
    logic signed [NORM_PROD_W-1:0] norm_as;
    logic signed [NORM_PROD_W-1:0] norm_bc;
  } prod_t;

  // Hand the roles on to the next axis: X(y,z,x) -> Y(z,x,y) -> Z(x,y,z).
  function automatic pair_t next_axis(input pair_t p);
    pair_t r;
    r.pos_a  = p.pos_b;
    r.pos_b  = p.pos_o;
    r.pos_o  = p.pos_a;
    r.norm_a = p.norm_b;
    r.norm_b = p.norm_o;
    r.norm_o = p.norm_a;
    return r;
  endfunction

  // Round to nearest (ties up) and clamp to the position range.
  function automatic logic signed [POS_W-1:0] rnd_sat_pos(
    input logic signed [POS_SUM_W-1:0] sum
  );
    logic signed [POS_SUM_W-1:0] r;
    logic signed [POS_SUM_W-1:0] hi;
    logic signed [POS_SUM_W-1:0] lo;
    r  = (sum + POS_SUM_W'(HALF)) >>> FRAC_SHIFT;
    hi = '0;
    hi[POS_W-2:0] = '1;
    lo = '1;
    lo[POS_W-2:0] = '0;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r[POS_W-1:0];
  endfunction

  // Round to nearest (ties up) and clamp to the normal range.
  function automatic logic signed [NORM_W-1:0] rnd_sat_norm(
    input logic signed [NORM_SUM_W-1:0] sum
  );
    logic signed [NORM_SUM_W-1:0] r;
    logic signed [NORM_SUM_W-1:0] hi;
    logic signed [NORM_SUM_W-1:0] lo;
    r  = (sum + NORM_SUM_W'(HALF)) >>> FRAC_SHIFT;
    hi = '0;
    hi[NORM_W-2:0] = '1;
    lo = '1;
    lo[NORM_W-2:0] = '0;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r[NORM_W-1:0];
  endfunction

endpackage

// ===== sv/euler_xyz_vertex_rotation.sv =====
// Euler X-Y-Z vertex rotation: six-register pipeline, two registers per axis.
// Each beat passes the X, Y and Z axes in that order, through each axis's multiply
// and round registers. Throughput: one vertex per cycle unless the master side stalls;
// each axis multiplies in one register stage and rounds/saturates in the next.
// Reset: async active low; empties the pipeline, coefficients to identity
// (cos 1.0, sin 0) and all axes off. Depends on exr_pkg and the defines header.
`include "euler_xyz_vertex_rotation_defines.svh"

module euler_xyz_vertex_rotation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [exr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [exr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Slave side; tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (lowest first)
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [exr_pkg::TDATA_W-1:0]         s_axis_tdata,
  // Master side; tdata: rot_pos_x, rot_pos_y, rot_pos_z, rot_norm_x,
  // rot_norm_y, rot_norm_z (lowest first)
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [exr_pkg::TDATA_W-1:0]         m_axis_tdata
);
  import exr_pkg::*;

  // Coefficient registers, Q2.14.
  logic signed [COEF_W-1:0]    cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;
  logic [AXIS_EN_W-1:0]        axis_en_q;

  axis_cfg_t cfg_x, cfg_y, cfg_z;
  vert_t     in_vert, out_vert;
  pair_t     x_in, x_out, y_in, y_out, z_in, z_out;
  logic      xy_valid, xy_ready, yz_valid, yz_ready;

  // The user must write only while idle; the block does not enforce it, and stages read the registers live.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_x_q   <= COEF_ONE;
      sin_x_q   <= '0;
      cos_y_q   <= COEF_ONE;
      sin_y_q   <= '0;
      cos_z_q   <= COEF_ONE;
      sin_z_q   <= '0;
      axis_en_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COS_X:   cos_x_q   <= cfg_data_i;
        REG_SIN_X:   sin_x_q   <= cfg_data_i;
        REG_COS_Y:   cos_y_q   <= cfg_data_i;
        REG_SIN_Y:   sin_y_q   <= cfg_data_i;
        REG_COS_Z:   cos_z_q   <= cfg_data_i;
        REG_SIN_Z:   sin_z_q   <= cfg_data_i;
        REG_AXIS_EN: axis_en_q <= cfg_data_i[AXIS_EN_W-1:0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

  assign cfg_x = '{en: axis_en_q[0], c: cos_x_q, s: sin_x_q};
  assign cfg_y = '{en: axis_en_q[1], c: cos_y_q, s: sin_y_q};
  assign cfg_z = '{en: axis_en_q[2], c: cos_z_q, s: sin_z_q};

  // Unpack the beat; the X axis rotates (y, z) and passes x.
  assign in_vert = vert_t'(s_axis_tdata[VERT_W-1:0]);

  always_comb begin
    x_in.pos_a  = in_vert.pos_y;
    x_in.pos_b  = in_vert.pos_z;
    x_in.pos_o  = in_vert.pos_x;
    x_in.norm_a = in_vert.norm_y;
    x_in.norm_b = in_vert.norm_z;
    x_in.norm_o = in_vert.norm_x;
  end

  // Y rotates (z, x), Z rotates (x, y): shift the roles between axes.
  assign y_in = next_axis(x_out);
  assign z_in = next_axis(y_out);

  exr_axis_stage u_axis_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_x),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_pair_i   (x_in),
    .out_valid_o (xy_valid),
    .out_ready_i (xy_ready),
    .out_pair_o  (x_out)
  );

  exr_axis_stage u_axis_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_y),
    .in_valid_i  (xy_valid),
    .in_ready_o  (xy_ready),
    .in_pair_i   (y_in),
    .out_valid_o (yz_valid),
    .out_ready_i (yz_ready),
    .out_pair_o  (y_out)
  );

  // The Z stage's last register doubles as the output register.
  exr_axis_stage u_axis_z (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_z),
    .in_valid_i  (yz_valid),
    .in_ready_o  (yz_ready),
    .in_pair_i   (z_in),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pair_o  (z_out)
  );

  always_comb begin
    out_vert.pos_x  = z_out.pos_a;
    out_vert.pos_y  = z_out.pos_b;
    out_vert.pos_z  = z_out.pos_o;
    out_vert.norm_x = z_out.norm_a;
    out_vert.norm_y = z_out.norm_b;
    out_vert.norm_z = z_out.norm_o;
  end

  // Zero-fill up to whole bytes.
  assign m_axis_tdata = TDATA_W'(out_vert);

  // Backpressure reaches the slave side only when the master side stalls.
  `EXR_ASSERT_NOW(a_ready_only_on_stall, clk_i, rst_ni, !s_axis_tready,
    m_axis_tvalid && !m_axis_tready, "slave stalled while master side moves")
  // Hold a stalled beat between the X and Y axes.
  `EXR_ASSERT_NEXT(a_xy_hold, clk_i, rst_ni, xy_valid && !xy_ready,
    xy_valid && $stable(x_out), "X to Y beat changed while stalled")
  // Hold a stalled beat between the Y and Z axes.
  `EXR_ASSERT_NEXT(a_yz_hold, clk_i, rst_ni, yz_valid && !yz_ready,
    yz_valid && $stable(y_out), "Y to Z beat changed while stalled")

endmodule

// ===== sv/exr_axis_stage.sv =====
// One axis rotation: a multiply register stage, then a round/saturate stage.
// Depends on exr_pkg.
module exr_axis_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  exr_pkg::axis_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  exr_pkg::pair_t    in_pair_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output exr_pkg::pair_t    out_pair_o
);
  import exr_pkg::*;

  logic  mul_vld_q, rnd_vld_q;
  logic  mul_en, rnd_en;
  prod_t prod_d, prod_q;
  pair_t hold_q;
  logic  ena_q;
  pair_t pair_d, pair_q;

  // Advance a stage when it is empty or its beat moves on.
  assign rnd_en     = !rnd_vld_q || out_ready_i;
  assign mul_en     = !mul_vld_q || rnd_en;
  assign in_ready_o = mul_en;

  always_comb begin
    prod_d.pos_ac  = POS_PROD_W'(in_pair_i.pos_a) * POS_PROD_W'(cfg_i.c);
    prod_d.pos_bs  = POS_PROD_W'(in_pair_i.pos_b) * POS_PROD_W'(cfg_i.s);
    prod_d.pos_as  = POS_PROD_W'(in_pair_i.pos_a) * POS_PROD_W'(cfg_i.s);
    prod_d.pos_bc  = POS_PROD_W'(in_pair_i.pos_b) * POS_PROD_W'(cfg_i.c);
    prod_d.norm_ac = NORM_PROD_W'(in_pair_i.norm_a) * NORM_PROD_W'(cfg_i.c);
    prod_d.norm_bs = NORM_PROD_W'(in_pair_i.norm_b) * NORM_PROD_W'(cfg_i.s);
    prod_d.norm_as = NORM_PROD_W'(in_pair_i.norm_a) * NORM_PROD_W'(cfg_i.s);
    prod_d.norm_bc = NORM_PROD_W'(in_pair_i.norm_b) * NORM_PROD_W'(cfg_i.c);
  end

  // a' = a*c - b*s, b' = a*s + b*c; pass through when the axis is off.
  always_comb begin
    pair_d = hold_q;
    if (ena_q) begin
      pair_d.pos_a  = rnd_sat_pos(POS_SUM_W'(prod_q.pos_ac) - POS_SUM_W'(prod_q.pos_bs));
      pair_d.pos_b  = rnd_sat_pos(POS_SUM_W'(prod_q.pos_as) + POS_SUM_W'(prod_q.pos_bc));
      pair_d.norm_a = rnd_sat_norm(NORM_SUM_W'(prod_q.norm_ac) - NORM_SUM_W'(prod_q.norm_bs));
      pair_d.norm_b = rnd_sat_norm(NORM_SUM_W'(prod_q.norm_as) + NORM_SUM_W'(prod_q.norm_bc));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      rnd_vld_q <= 1'b0;
    end else begin
      if (mul_en) begin
        mul_vld_q <= in_valid_i;
      end
      if (rnd_en) begin
        rnd_vld_q <= mul_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= prod_d;
      hold_q <= in_pair_i;
      ena_q  <= cfg_i.en;
    end
    if (rnd_en) begin
      pair_q <= pair_d;
    end
  end

  assign out_valid_o = rnd_vld_q;
  assign out_pair_o  = pair_q;

endmodule

// ===== sim/euler_xyz_vertex_rotation_checker.sv =====
// Scoreboard for the Euler X-Y-Z vertex rotation block: predicts each rotated vertex.
// Depends on exr_pkg for widths, register indexes and the vertex layout.
`timescale 1ns / 100ps

module euler_xyz_vertex_rotation_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [exr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [exr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (lowest first)
  input  logic [exr_pkg::TDATA_W-1:0]    s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // rot_pos_x, rot_pos_y, rot_pos_z, rot_norm_x, rot_norm_y, rot_norm_z (lowest first)
  input  logic [exr_pkg::TDATA_W-1:0]    m_axis_tdata,
  output int                             pending_o,
  output int                             mismatches_o,
  output int                             checked_o
);
  import exr_pkg::*;

  logic signed [COEF_W-1:0] cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;
  logic [AXIS_EN_W-1:0]     axis_en_q;

  vert_t rotated_q[$];
  vert_t got_beat;
  vert_t want_beat;
  int    mismatch_cnt;
  int    checked_cnt;

  assign mismatches_o = mismatch_cnt;
  assign checked_o    = checked_cnt;

  // Round the Q2.14-scaled sum to nearest (ties up), then clamp to w bits.
  function automatic longint round_clamp(input longint sum, input int w);
    longint r;
    longint hi;
    longint lo;
    r  = (sum + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (r > hi) return hi;
    if (r < lo) return lo;
    return r;
  endfunction

  // a' = a*c - b*s ; b' = a*s + b*c
  function automatic void turn_pair(inout longint a, inout longint b,
                                    input longint c, input longint s, input int w);
    longint na;
    longint nb;
    na = round_clamp(a * c - b * s, w);
    nb = round_clamp(a * s + b * c, w);
    a  = na;
    b  = nb;
  endfunction

  function automatic vert_t rotate_vertex(input vert_t v);
    longint px, py, pz, nx, ny, nz;
    vert_t  r;
    px = longint'(v.pos_x);
    py = longint'(v.pos_y);
    pz = longint'(v.pos_z);
    nx = longint'(v.norm_x);
    ny = longint'(v.norm_y);
    nz = longint'(v.norm_z);
    if (axis_en_q[0]) begin
      turn_pair(py, pz, longint'(cos_x_q), longint'(sin_x_q), POS_W);
      turn_pair(ny, nz, longint'(cos_x_q), longint'(sin_x_q), NORM_W);
    end
    if (axis_en_q[1]) begin
      turn_pair(pz, px, longint'(cos_y_q), longint'(sin_y_q), POS_W);
      turn_pair(nz, nx, longint'(cos_y_q), longint'(sin_y_q), NORM_W);
    end
    if (axis_en_q[2]) begin
      turn_pair(px, py, longint'(cos_z_q), longint'(sin_z_q), POS_W);
      turn_pair(nx, ny, longint'(cos_z_q), longint'(sin_z_q), NORM_W);
    end
    r.pos_x  = px[POS_W-1:0];
    r.pos_y  = py[POS_W-1:0];
    r.pos_z  = pz[POS_W-1:0];
    r.norm_x = nx[NORM_W-1:0];
    r.norm_y = ny[NORM_W-1:0];
    r.norm_z = nz[NORM_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_x_q   = COEF_ONE;
      sin_x_q   = '0;
      cos_y_q   = COEF_ONE;
      sin_y_q   = '0;
      cos_z_q   = COEF_ONE;
      sin_z_q   = '0;
      axis_en_q = '0;
      rotated_q.delete();
      mismatch_cnt = 0;
      checked_cnt  = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_COS_X:   cos_x_q = cfg_data_i;
          REG_SIN_X:   sin_x_q = cfg_data_i;
          REG_COS_Y:   cos_y_q = cfg_data_i;
          REG_SIN_Y:   sin_y_q = cfg_data_i;
          REG_COS_Z:   cos_z_q = cfg_data_i;
          REG_SIN_Z:   sin_z_q = cfg_data_i;
          REG_AXIS_EN: axis_en_q = cfg_data_i[AXIS_EN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rotated_q.insert(rotated_q.size(), rotate_vertex(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_beat = m_axis_tdata;
        if (rotated_q.size() == 0) begin
          $error("result beat with no vertex pending");
          mismatch_cnt++;
        end else begin
          want_beat = rotated_q.pop_front();
          check_field("rot_pos_x",  longint'(want_beat.pos_x),  longint'(got_beat.pos_x));
          check_field("rot_pos_y",  longint'(want_beat.pos_y),  longint'(got_beat.pos_y));
          check_field("rot_pos_z",  longint'(want_beat.pos_z),  longint'(got_beat.pos_z));
          check_field("rot_norm_x", longint'(want_beat.norm_x), longint'(got_beat.norm_x));
          check_field("rot_norm_y", longint'(want_beat.norm_y), longint'(got_beat.norm_y));
          check_field("rot_norm_z", longint'(want_beat.norm_z), longint'(got_beat.norm_z));
          checked_cnt++;
        end
      end
      pending_o <= rotated_q.size();
    end
  end

endmodule

// ===== sim/tb_euler_xyz_vertex_rotation.sv =====
// Testbench top for the Euler X-Y-Z vertex rotation block: stimulus and verdict.
// Depends on exr_pkg, the block itself and euler_xyz_vertex_rotation_checker.
`timescale 1ns / 100ps

module tb_euler_xyz_vertex_rotation;
  import exr_pkg::*;

  localparam int RANDOM_VERTS = 750;
  localparam int MAX_IDLE     = 18;    // longest sender gap or receiver stall
  localparam int DRAIN_TAIL   = 8;     // extra settle time once nothing is pending
  localparam int STALL_LIMIT  = 1000;  // cycles without any beat or write

  // Axis enable masks.
  localparam logic [AXIS_EN_W-1:0] AXIS_X   = 3'b001;
  localparam logic [AXIS_EN_W-1:0] AXIS_Y   = 3'b010;
  localparam logic [AXIS_EN_W-1:0] AXIS_Z   = 3'b100;
  localparam logic [AXIS_EN_W-1:0] AXES_ALL = 3'b111;

  // Index with no register behind it; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};
  localparam logic signed [NORM_W-1:0] NORM_MIN = {1'b1, {(NORM_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_HALF = COEF_ONE >>> 1;
  localparam logic signed [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;

  int pending_cnt;
  int mismatch_cnt;
  int checked_cnt;

  int   sent_cnt    = 0;
  int   setting_cnt = 0;
  logic tx_fast     = 1'b0;  // sender runs back to back when set
  logic rx_fast     = 1'b0;  // receiver never stalls when set
  int   rx_hold     = 0;
  int   rx_draw;
  int   quiet_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  euler_xyz_vertex_rotation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  euler_xyz_vertex_rotation_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending_cnt),
    .mismatches_o  (mismatch_cnt),
    .checked_o     (checked_cnt)
  );

  // Receiver: after each result beat, drop tready for a drawn number of
  // cycles, then raise it and hold it until the next beat lands.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rx_draw = rx_fast ? 0 : $urandom_range(0, MAX_IDLE);
      m_axis_tready <= (rx_draw == 0);
      rx_hold       <= rx_draw;
    end else if (!m_axis_tready) begin
      if (rx_hold <= 1) begin
        m_axis_tready <= 1'b1;
      end
      rx_hold <= rx_hold - 1;
    end
  end

  // Watchdog: any beat on either side or any register write counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no progress for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic vert_t mk_vert(
    input logic signed [POS_W-1:0]  px, py, pz,
    input logic signed [NORM_W-1:0] nx, ny, nz
  );
    vert_t v;
    v.pos_x  = px;
    v.pos_y  = py;
    v.pos_z  = pz;
    v.norm_x = nx;
    v.norm_y = ny;
    v.norm_z = nz;
    return v;
  endfunction

  // Positions: mostly everyday coordinates, with rails and raw bit patterns mixed in.
  function automatic logic signed [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return $urandom;
      3:       return '0;
      default: return $urandom_range(0, 1 << 24) - (1 << 23);
    endcase
  endfunction

  // Normals: unit-length components mostly, rails and raw patterns sometimes.
  function automatic logic signed [NORM_W-1:0] pick_norm();
    case ($urandom_range(0, 7))
      0:       return NORM_MAX;
      1:       return NORM_MIN;
      2:       return NORM_W'($urandom);
      default: return NORM_W'($urandom_range(0, 2 * COEF_ONE) - COEF_ONE);
    endcase
  endfunction

  // Coefficients: mostly inside +-1.0, sometimes the edges or any 16-bit code.
  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_ONE;
      1:       return -COEF_ONE;
      2:       return '0;
      3:       return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(0, 2 * COEF_ONE) - COEF_ONE);
    endcase
  endfunction

  function automatic vert_t random_vertex();
    return mk_vert(pick_pos(), pick_pos(), pick_pos(), pick_norm(), pick_norm(), pick_norm());
  endfunction

  // Present one write for one edge; the caller drops cfg_we_i after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_axes(
    input logic signed [COEF_W-1:0] cx, sx, cy, sy, cz, sz,
    input logic [AXIS_EN_W-1:0]     en
  );
    write_reg(REG_COS_X, cx);
    write_reg(REG_SIN_X, sx);
    write_reg(REG_COS_Y, cy);
    write_reg(REG_SIN_Y, sy);
    write_reg(REG_COS_Z, cz);
    write_reg(REG_SIN_Z, sz);
    write_reg(REG_AXIS_EN, CFG_DATA_W'(en));
    cfg_we_i <= 1'b0;
  endtask

  // Hand one vertex over; tvalid stays high on return so a zero gap runs back to back.
  task automatic run_vertex(input vert_t v);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Stop sending and wait for every predicted vertex, then let the pipe settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  initial begin
    int burst_len;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: all axes off, vertices pass through untouched.
    run_vertex(mk_vert('0, '0, '0, '0, '0, '0));
    run_vertex(mk_vert(POS_MAX, POS_MAX, POS_MAX, NORM_MAX, NORM_MAX, NORM_MAX));
    run_vertex(mk_vert(POS_MIN, POS_MIN, POS_MIN, NORM_MIN, NORM_MIN, NORM_MIN));
    run_vertex(mk_vert(POS_MAX, POS_MIN, '0, NORM_MIN, NORM_MAX, '0));
    wait_drained();

    // Identity coefficients with every axis on: exact, no rounding.
    apply_axes(COEF_ONE, '0, COEF_ONE, '0, COEF_ONE, '0, AXES_ALL);
    run_vertex(mk_vert(POS_MAX, POS_MIN, POS_MAX, NORM_MAX, NORM_MIN, NORM_MAX));
    run_vertex(mk_vert(POS_MIN, POS_MAX, POS_MIN, NORM_MIN, NORM_MAX, NORM_MIN));
    wait_drained();

    // cos = sin = 1.0 doubles magnitudes: drive every stage into saturation.
    apply_axes(COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE, AXES_ALL);
    run_vertex(mk_vert(POS_MAX, POS_MAX, POS_MAX, NORM_MAX, NORM_MAX, NORM_MAX));
    run_vertex(mk_vert(POS_MIN, POS_MIN, POS_MIN, NORM_MIN, NORM_MIN, NORM_MIN));
    run_vertex(mk_vert(POS_MAX, POS_MIN, POS_MAX, NORM_MIN, NORM_MAX, NORM_MIN));
    wait_drained();

    // Out-of-range coefficient codes on X alone: taken as plain two's complement.
    apply_axes(COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, AXIS_X);
    run_vertex(mk_vert(POS_MAX, POS_MIN, POS_MAX, NORM_MAX, NORM_MIN, NORM_MAX));
    run_vertex(random_vertex());
    wait_drained();

    // Quarter turn about Y only.
    apply_axes(COEF_ONE, '0, '0, COEF_ONE, COEF_ONE, '0, AXIS_Y);
    run_vertex(mk_vert(POS_MAX, 32'sd65536, POS_MIN, NORM_MAX, 16'sd1, NORM_MIN));
    run_vertex(random_vertex());
    wait_drained();

    // Z only, with the largest positive code and minus one.
    apply_axes(COEF_ONE, '0, COEF_ONE, '0, COEF_MAX, -COEF_ONE, AXIS_Z);
    run_vertex(mk_vert(32'sd12345, -32'sd9876, '0, 16'sd333, -16'sd777, '0));
    run_vertex(random_vertex());
    wait_drained();

    // Halving on X makes odd inputs land exactly on a half: ties must round up.
    // Also poke the unused index, which must leave the setting alone.
    apply_axes(COEF_HALF, '0, COEF_ONE, '0, COEF_ONE, '0, AXIS_X);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    run_vertex(mk_vert('0, 32'sd1, -32'sd1, '0, 16'sd1, -16'sd1));
    run_vertex(mk_vert('0, 32'sd3, -32'sd3, '0, -16'sd3, 16'sd3));
    run_vertex(mk_vert('0, POS_MAX, POS_MIN, '0, NORM_MAX, NORM_MIN));
    wait_drained();
    setting_cnt = 7;

    // Random part: each burst rewrites a random subset of the coefficients and
    // always the axis enables, then streams vertices and drains completely.
    while (sent_cnt < RANDOM_VERTS + 20) begin
      if ($urandom_range(0, 1)) write_reg(REG_COS_X, pick_coef());
      if ($urandom_range(0, 1)) write_reg(REG_SIN_X, pick_coef());
      if ($urandom_range(0, 1)) write_reg(REG_COS_Y, pick_coef());
      if ($urandom_range(0, 1)) write_reg(REG_SIN_Y, pick_coef());
      if ($urandom_range(0, 1)) write_reg(REG_COS_Z, pick_coef());
      if ($urandom_range(0, 1)) write_reg(REG_SIN_Z, pick_coef());
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      // Upper data bits are don't-care for the enables; toggle them anyway.
      write_reg(REG_AXIS_EN, CFG_DATA_W'($urandom));
      cfg_we_i <= 1'b0;

      // Some bursts run without any gaps on one side or both.
      tx_fast <= ($urandom_range(0, 3) == 0);
      rx_fast <= ($urandom_range(0, 3) == 0);
      burst_len = $urandom_range(10, 60);
      repeat (burst_len) run_vertex(random_vertex());
      wait_drained();
      setting_cnt++;
    end

    $display("Streamed %0d vertices through %0d register settings, all axis combinations",
             sent_cnt, setting_cnt);
    $display("with saturation, rounding ties and odd coefficient codes; %0d results checked.",
             checked_cnt);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
